// ===== rtl/atr_hbx_pkg.sv =====
// Shared types and codes for the answer-to-reset historical byte extractor.
`timescale 1ns / 1ps

package atr_hbx_pkg;

   localparam int unsigned ByteW = 8;
   localparam int unsigned StatW = 2;
   localparam int unsigned NibW  = 4;

   localparam logic [ByteW-1:0] TS_DIRECT  = 8'h3B;
   localparam logic [ByteW-1:0] TS_INVERSE = 8'h3F;

   localparam logic [NibW-1:0] IF_TA = 4'h1;
   localparam logic [NibW-1:0] IF_TB = 4'h2;
   localparam logic [NibW-1:0] IF_TC = 4'h4;
   localparam logic [NibW-1:0] IF_TD = 4'h8;

   localparam logic [StatW-1:0] ST_HIST  = 2'd0;
   localparam logic [StatW-1:0] ST_NONE  = 2'd1;
   localparam logic [StatW-1:0] ST_NO_TS = 2'd2;

   typedef struct packed {
      logic [ByteW-1:0] rx_byte;
      logic             restart;
      logic             final_byte;
   } item_type;

   typedef struct packed {
      logic [ByteW-1:0] hist_byte;
      logic [StatW-1:0] status;
      logic             last;
   } result_type;

endpackage

// ===== rtl/atr_historical_byte_extractor.sv =====
// Top level of the answer-to-reset historical byte extractor.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  rx_byte, restart, final_byte
//   rsp       out        rsp_valid/rsp_stall  hist_byte, status, last
//
// One item per cycle unless rsp stalls; an item's result, if due, is registered before rsp.
// Throughput is set by the single parse step between the input and result registers.
// Reset (synchronous) empties both registers and returns the parser to waiting for TS.
// A stall on rsp holds the result; req stalls only if rsp stalls with both registers full.
`timescale 1ns / 1ps

module atr_historical_byte_extractor (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [atr_hbx_pkg::ByteW-1:0] req_rx_byte,
   input  logic                          req_restart,
   input  logic                          req_final_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [atr_hbx_pkg::ByteW-1:0] rsp_hist_byte,
   output logic [atr_hbx_pkg::StatW-1:0] rsp_status,
   output logic                          rsp_last
);
   import atr_hbx_pkg::*;

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   logic       res_valid;
   result_type res;
   result_type rsp_res;

   assign req_item = '{rx_byte: req_rx_byte, restart: req_restart,
                       final_byte: req_final_byte};

   atr_hbx_inreg u_inreg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   atr_hbx_step u_step (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   atr_hbx_outreg u_outreg (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .res_valid  (res_valid),
      .res        (res),
      .advance    (advance),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_res    (rsp_res)
   );

   assign rsp_hist_byte = rsp_res.hist_byte;
   assign rsp_status    = rsp_res.status;
   assign rsp_last      = rsp_res.last;

endmodule

// ===== rtl/atr_hbx_inreg.sv =====
// Input register stage: captures one item and hands it to the parser.
`timescale 1ns / 1ps

module atr_hbx_inreg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  atr_hbx_pkg::item_type req_item,
   input  logic                  advance,
   output logic                  item_valid,
   output atr_hbx_pkg::item_type item
);
   import atr_hbx_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_stall  = valid_ff && !advance;
   assign valid_in   = req_valid || (valid_ff && !advance);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && !req_stall) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== rtl/atr_hbx_step.sv =====
// Parse state and the per-byte step that decides whether a result is due.
`timescale 1ns / 1ps

module atr_hbx_step (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  atr_hbx_pkg::item_type   item,
   output logic                    res_valid,
   output atr_hbx_pkg::result_type res
);
   import atr_hbx_pkg::*;

   typedef enum logic [1:0] {
      PH_WAIT_TS,
      PH_FORMAT,
      PH_IFACE,
      PH_HIST
   } phase_type;

   phase_type        phase_ff, phase_in, phase_cur;
   logic [NibW-1:0]  mask_ff, mask_in, mask_cur;
   logic [NibW-1:0]  rem_ff, rem_in, rem_cur;
   logic             fin_ff, fin_in, fin_cur;
   logic [NibW-1:0]  hi_nib;

   assign hi_nib = item.rx_byte[ByteW-1:NibW];

   always_comb begin
      phase_cur = item.restart ? PH_WAIT_TS : phase_ff;
      mask_cur  = item.restart ? '0 : mask_ff;
      rem_cur   = item.restart ? '0 : rem_ff;
      fin_cur   = item.restart ? 1'b0 : fin_ff;
      phase_in  = phase_cur;
      mask_in   = mask_cur;
      rem_in    = rem_cur;
      fin_in    = fin_cur;
      res_valid = 1'b0;
      res       = '{hist_byte: '0, status: ST_NONE, last: 1'b1};
      if (!fin_cur) begin
         case (phase_cur)
            PH_WAIT_TS: begin
               if (item.rx_byte == TS_DIRECT || item.rx_byte == TS_INVERSE) begin
                  phase_in  = PH_FORMAT;
                  res_valid = item.final_byte;
               end else if (item.final_byte) begin
                  res_valid  = 1'b1;
                  res.status = ST_NO_TS;
               end
            end
            PH_FORMAT: begin
               mask_in = hi_nib;
               rem_in  = item.rx_byte[NibW-1:0];
               if (hi_nib != '0) begin
                  phase_in  = PH_IFACE;
                  res_valid = item.final_byte;
               end else if (item.final_byte) begin
                  res_valid = 1'b1;
               end else if (item.rx_byte[NibW-1:0] != '0) begin
                  phase_in = PH_HIST;
               end else begin
                  fin_in    = 1'b1;
                  res_valid = 1'b1;
               end
            end
            PH_IFACE: begin
               if ((mask_cur & IF_TA) != '0) begin
                  mask_in = mask_cur & ~IF_TA;
               end else if ((mask_cur & IF_TB) != '0) begin
                  mask_in = mask_cur & ~IF_TB;
               end else if ((mask_cur & IF_TC) != '0) begin
                  mask_in = mask_cur & ~IF_TC;
               end else begin
                  mask_in = hi_nib;
               end
               if (item.final_byte) begin
                  res_valid = 1'b1;
               end else if (mask_in == '0) begin
                  if (rem_cur != '0) begin
                     phase_in = PH_HIST;
                  end else begin
                     fin_in    = 1'b1;
                     res_valid = 1'b1;
                  end
               end
            end
            PH_HIST: begin
               rem_in        = rem_cur - NibW'(1);
               res_valid     = 1'b1;
               res.hist_byte = item.rx_byte;
               res.status    = ST_HIST;
               res.last      = (rem_in == '0) || item.final_byte;
               fin_in        = res.last;
            end
            default: begin
               phase_in = PH_WAIT_TS;
            end
         endcase
      end
      if (item.final_byte) begin
         phase_in = PH_WAIT_TS;
         mask_in  = '0;
         rem_in   = '0;
         fin_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT_TS;
         mask_ff  <= '0;
         rem_ff   <= '0;
         fin_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         mask_ff  <= mask_in;
         rem_ff   <= rem_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

// ===== rtl/atr_hbx_outreg.sv =====
// Result register: holds one result item until the receiver takes it.
`timescale 1ns / 1ps

module atr_hbx_outreg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  logic                    res_valid,
   input  atr_hbx_pkg::result_type res,
   output logic                    advance,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output atr_hbx_pkg::result_type rsp_res
);
   import atr_hbx_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic       free;
   result_type res_ff;

   assign free      = !valid_ff || !rsp_stall;
   assign advance   = item_valid && free;
   assign valid_in  = advance ? res_valid : (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance && res_valid) begin
         res_ff <= res;
      end
   end

endmodule

// ===== rtl/atr_hbx_checks.sv =====
// Port-level checks for the historical byte extractor, bound to the top level.
`timescale 1ns / 1ps

module atr_hbx_checks (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_hist_byte,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);
   import atr_hbx_pkg::*;

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_HIST || rsp_status == ST_NONE ||
                     rsp_status == ST_NO_TS))
      else $error("bad status code");

   a_report_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_HIST) |-> (rsp_last && rsp_hist_byte == '0))
      else $error("report item not last or carries a byte");

   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      (req_stall && !$past(reset)) |-> $past(req_valid || req_stall))
      else $error("input stalled with nothing held");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_hist_byte) &&
                                    $stable(rsp_status) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind atr_historical_byte_extractor atr_hbx_checks u_checks (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_hist_byte (rsp_hist_byte),
   .rsp_status    (rsp_status),
   .rsp_last      (rsp_last)
);

// ===== verif/atr_hbx_check.sv =====
// Predicts historical-byte results from accepted items and compares them with the rsp channel.
`timescale 1ns / 1ps

module atr_hbx_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [atr_hbx_pkg::ByteW-1:0] req_rx_byte,
   input  logic                          req_restart,
   input  logic                          req_final_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [atr_hbx_pkg::ByteW-1:0] rsp_hist_byte,
   input  logic [atr_hbx_pkg::StatW-1:0] rsp_status,
   input  logic                          rsp_last,
   output int                            mismatches,
   output int                            pending
);
   import atr_hbx_pkg::*;

   typedef enum logic [2:0] {
      PARSE_WAIT_TS = 3'd0,
      PARSE_FORMAT  = 3'd1,
      PARSE_IFACE   = 3'd2,
      PARSE_HIST    = 3'd3
   } parse_phase_type;

   parse_phase_type  parse_phase;
   logic [NibW-1:0]  iface_due;
   logic [NibW-1:0]  hist_left;
   logic             atr_done;
   result_type       hist_expected_q[$];
   int               errs = 0;

   function void clear_parse();
      parse_phase = PARSE_WAIT_TS;
      iface_due   = '0;
      hist_left   = '0;
      atr_done    = 1'b0;
   endfunction

   // interface groups are over: move on to historical bytes, or report that there are none
   function bit leave_interface();
      if (hist_left != 0) begin
         parse_phase = PARSE_HIST;
         return 1'b0;
      end
      atr_done = 1'b1;
      return 1'b1;
   endfunction

   function automatic bit parse_atr_byte(input item_type it, output result_type res);
      bit              hit;
      bit              report_none;
      logic [NibW-1:0] m;
      hit         = 1'b0;
      report_none = 1'b0;
      res         = '0;
      if (it.restart) clear_parse();
      if (!atr_done) begin
         case (parse_phase)
            PARSE_WAIT_TS: begin
               if (it.rx_byte == TS_DIRECT || it.rx_byte == TS_INVERSE) begin
                  parse_phase = PARSE_FORMAT;
                  report_none = it.final_byte;
               end else if (it.final_byte) begin
                  hit        = 1'b1;
                  res.status = ST_NO_TS;
                  res.last   = 1'b1;
               end
            end
            PARSE_FORMAT: begin
               iface_due = it.rx_byte[7:4];
               hist_left = it.rx_byte[3:0];
               if (iface_due != 0) begin
                  parse_phase = PARSE_IFACE;
                  report_none = it.final_byte;
               end else if (it.final_byte) begin
                  report_none = 1'b1;
               end else begin
                  report_none = leave_interface();
               end
            end
            PARSE_IFACE: begin
               m = iface_due;
               if ((m & IF_TA) != 0) m = m & ~IF_TA;
               else if ((m & IF_TB) != 0) m = m & ~IF_TB;
               else if ((m & IF_TC) != 0) m = m & ~IF_TC;
               else m = it.rx_byte[7:4];
               iface_due = m;
               if (it.final_byte) report_none = 1'b1;
               else if (m == 0) report_none = leave_interface();
            end
            PARSE_HIST: begin
               hist_left     = hist_left - NibW'(1);
               hit           = 1'b1;
               res.hist_byte = it.rx_byte;
               res.status    = ST_HIST;
               res.last      = (hist_left == 0) || it.final_byte;
               if (res.last) atr_done = 1'b1;
            end
            default: ;
         endcase
      end
      if (report_none) begin
         hit        = 1'b1;
         res.status = ST_NONE;
         res.last   = 1'b1;
      end
      if (it.final_byte) clear_parse();
      return hit;
   endfunction

   always @(posedge clock) begin : watch
      item_type   seen;
      result_type want;
      result_type got;
      if (reset) begin
         clear_parse();
         hist_expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (hist_expected_q.size() == 0) begin
               $error("unexpected result: hist_byte %0h status %0d last %0d",
                      rsp_hist_byte, rsp_status, rsp_last);
               errs++;
            end else begin
               want = hist_expected_q.pop_front();
               if (rsp_hist_byte !== want.hist_byte) begin
                  $error("hist_byte mismatch: expected %0h, actual %0h",
                         want.hist_byte, rsp_hist_byte);
                  errs++;
               end
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
                  errs++;
               end
               if (rsp_last !== want.last) begin
                  $error("last mismatch: expected %0d, actual %0d", want.last, rsp_last);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            seen.rx_byte    = req_rx_byte;
            seen.restart    = req_restart;
            seen.final_byte = req_final_byte;
            if (parse_atr_byte(seen, got)) hist_expected_q = {hist_expected_q, got};
         end
      end
      mismatches <= errs;
      pending    <= hist_expected_q.size();
   end

endmodule

// ===== verif/tb_atr_historical_byte_extractor.sv =====
// Top of the historical byte extractor testbench: clock, reset, ATR stimulus and verdict.
`timescale 1ns / 1ps

module tb_atr_historical_byte_extractor;
   import atr_hbx_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int PhaseItems    = 420;

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_stall;
   logic [ByteW-1:0] req_rx_byte    = '0;
   logic             req_restart    = 1'b0;
   logic             req_final_byte = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall      = 1'b0;
   logic [ByteW-1:0] rsp_hist_byte;
   logic [StatW-1:0] rsp_status;
   logic             rsp_last;

   int mismatches;
   int pending;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int items_sent     = 0;
   int quiet_cycles   = 0;

   atr_historical_byte_extractor dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .req_restart    (req_restart),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hist_byte  (rsp_hist_byte),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

   atr_hbx_check u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .req_restart    (req_restart),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hist_byte  (rsp_hist_byte),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .mismatches     (mismatches),
      .pending        (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WatchdogLimit) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_byte(input logic [ByteW-1:0] b, input logic rs, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_rx_byte    <= b;
      req_restart    <= rs;
      req_final_byte <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   function automatic item_type atr_char(input logic [ByteW-1:0] b);
      item_type it;
      it         = '0;
      it.rx_byte = b;
      return it;
   endfunction

   // well-formed ATR with random content; sometimes noise ahead, a cut end or no end flag
   task automatic send_random_atr();
      item_type        seq[$];
      logic [NibW-1:0] y;
      logic [NibW-1:0] k;
      logic [ByteW-1:0] td;
      int              groups;
      int              mode;
      int              cut;
      groups = 0;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(3, 1)) seq = {seq, atr_char(8'($urandom_range(255)))};
      end
      seq = {seq, atr_char($urandom_range(1) ? TS_INVERSE : TS_DIRECT)};
      y = 4'($urandom_range(15));
      k = 4'($urandom_range(15));
      seq = {seq, atr_char({y, k})};
      while (y != 0) begin
         if ((y & IF_TA) != 0) seq = {seq, atr_char(8'($urandom_range(255)))};
         if ((y & IF_TB) != 0) seq = {seq, atr_char(8'($urandom_range(255)))};
         if ((y & IF_TC) != 0) seq = {seq, atr_char(8'($urandom_range(255)))};
         if ((y & IF_TD) != 0) begin
            td = 8'($urandom_range(255));
            if (groups >= 3) td[7:4] = '0;
            seq = {seq, atr_char(td)};
            y = td[7:4];
            groups++;
         end else begin
            y = '0;
         end
      end
      repeat (k) seq = {seq, atr_char(8'($urandom_range(255)))};
      if ($urandom_range(1)) seq = {seq, atr_char(8'($urandom_range(255)))};
      mode = $urandom_range(9);
      if (mode < 7) begin
         seq[seq.size()-1].final_byte = 1'b1;
      end else if (mode == 7) begin
         cut = $urandom_range(seq.size() - 1);
         seq[cut].final_byte = 1'b1;
         seq = seq[0:cut];
      end
      if ($urandom_range(3) == 0) seq[0].restart = 1'b1;
      foreach (seq[i]) send_byte(seq[i].rx_byte, seq[i].restart, seq[i].final_byte);
   endtask

   initial begin
      int target;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct  = 24;
      recv_stall_pct = 87;

      send_byte(8'h00, 1'b0, 1'b1);
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(TS_DIRECT, 1'b0, 1'b1);

      send_byte(TS_INVERSE, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'h55, 1'b0, 1'b0);
      send_byte(8'hAA, 1'b0, 1'b1);

      send_byte(TS_DIRECT, 1'b0, 1'b0);
      send_byte(8'h81, 1'b0, 1'b0);
      send_byte(8'hF0, 1'b0, 1'b0);
      send_byte(8'h12, 1'b0, 1'b0);
      send_byte(8'h34, 1'b0, 1'b0);
      send_byte(8'h56, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'hEE, 1'b0, 1'b1);

      send_byte(TS_DIRECT, 1'b0, 1'b0);
      send_byte(8'h1F, 1'b0, 1'b0);
      send_byte(TS_INVERSE, 1'b1, 1'b0);
      send_byte(8'h02, 1'b0, 1'b1);

      send_byte(TS_DIRECT, 1'b0, 1'b0);
      send_byte(8'h2F, 1'b0, 1'b0);
      send_byte(8'h77, 1'b0, 1'b1);

      send_byte(TS_DIRECT, 1'b0, 1'b0);
      send_byte(8'h05, 1'b0, 1'b0);
      send_byte(8'h11, 1'b0, 1'b0);
      send_byte(8'h22, 1'b0, 1'b1);

      for (int p = 0; p < 3; p++) begin
         send_idle_pct  = (p == 0) ? 24 : (p == 1) ? 87 : 0;
         recv_stall_pct = (p == 0) ? 87 : (p == 1) ? 24 : 0;
         target = items_sent + PhaseItems;
         while (items_sent < target) begin
            if ($urandom_range(99) < 15)
               send_byte(8'($urandom_range(255)), $urandom_range(7) == 0,
                         $urandom_range(7) == 0);
            else
               send_random_atr();
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== atr_historical_byte_extractor.f =====
rtl/atr_hbx_pkg.sv
rtl/atr_hbx_inreg.sv
rtl/atr_hbx_step.sv
rtl/atr_hbx_outreg.sv
rtl/atr_historical_byte_extractor.sv
rtl/atr_hbx_checks.sv
verif/atr_hbx_check.sv
verif/tb_atr_historical_byte_extractor.sv
